// ===== sv/adc_conversion_register_block_assert.svh =====
// Assertion macros for the ADC register block checker.
`ifndef ADC_CONVERSION_REGISTER_BLOCK_ASSERT_SVH
`define ADC_CONVERSION_REGISTER_BLOCK_ASSERT_SVH

// Same-cycle implication.
`define ACRB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adc register block check failed");

// Next-cycle implication.
`define ACRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adc register block check failed");

`endif

// ===== sv/acrb_pkg.sv =====
`default_nettype none
package acrb_pkg;

  localparam int CHANNELS_DEF       = 32;
  localparam int GROUPS_DEF         = 3;
  localparam int LIMIT_REGS_DEF     = 4;
  localparam int SELFTEST_TICKS_DEF = 80;

  localparam int RES_W   = 12;
  localparam int LEVEL_W = 16;

  localparam logic [2:0] ACT_READ  = 3'd0;
  localparam logic [2:0] ACT_WRITE = 3'd1;
  localparam logic [2:0] ACT_TICK  = 3'd2;
  localparam logic [2:0] ACT_LEVEL = 3'd3;
  localparam logic [2:0] ACT_TRIG  = 3'd4;

  localparam logic [11:0] A_CTRL  = 12'h000;
  localparam logic [11:0] A_STAT  = 12'h004;
  localparam logic [11:0] A_END   = 12'h010;
  localparam logic [11:0] A_DONE  = 12'h014;
  localparam logic [11:0] A_ENDM  = 12'h020;
  localparam logic [11:0] A_INTM  = 12'h024;
  localparam logic [11:0] A_WSTAT = 12'h030;
  localparam logic [11:0] A_WMASK = 12'h034;
  localparam logic [11:0] A_DMAE  = 12'h040;
  localparam logic [11:0] A_DMAR  = 12'h044;
  localparam logic [11:0] A_LIM   = 12'h060;
  localparam logic [11:0] A_TIM   = 12'h094;
  localparam logic [11:0] A_NMASK = 12'h0A4;
  localparam logic [11:0] A_JMASK = 12'h0B4;
  localparam logic [11:0] A_DELAY = 12'h0C4;
  localparam logic [11:0] A_CAL0  = 12'h3A0;
  localparam logic [11:0] A_CAL1  = 12'h3A4;
  localparam logic [11:0] A_CAL2  = 12'h3A8;

  localparam logic [11:0] DATA_BASE [3] = '{12'h100, 12'h180, 12'h200};
  localparam int          DATA_CNT  [3] = '{8, 24, 32};

  localparam int PWDN_BIT   = 0;
  localparam int MODEW_BIT  = 1;
  localparam int NSTART_BIT = 7;
  localparam int JSTART_BIT = 24;
  localparam int VALID_BIT  = 19;

  localparam logic [1:0]  SCAN_CONT  = 2'd2;
  localparam logic [31:0] CTRL_RST   = 32'h1;
  localparam logic [31:0] STAT_RST   = 32'h1;
  localparam logic [31:0] TIMING_RST = 32'h16;
  localparam logic [31:0] CAL0_VAL   = 32'd400;
  localparam logic [31:0] CAL1_VAL   = 32'd0;
  localparam logic [31:0] CAL2_VAL   = 32'd0;

  localparam logic [3:0] NIB_IDLE = 4'd1;
  localparam logic [3:0] NIB_ZERO = 4'd0;
  localparam logic [3:0] NIB_CONV = 4'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SWEEP, S_DRAIN, S_TAIL, S_FINISH
  } state_t;

endpackage
`default_nettype wire

// ===== sv/acrb_level_mem.sv =====
`default_nettype none
module acrb_level_mem #(
  parameter int CHANNELS = acrb_pkg::CHANNELS_DEF,
  parameter int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        we,
  input  logic [CW-1:0]               waddr,
  input  logic [acrb_pkg::LEVEL_W-1:0] wdata,
  input  logic [CW-1:0]               raddr,
  output logic [acrb_pkg::LEVEL_W-1:0] rd_data,
  output logic                        rd_ok
);
  import acrb_pkg::*;

  logic [LEVEL_W-1:0] mem [CHANNELS];
  logic [CHANNELS-1:0] written;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      rd_ok <= written[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/acrb_result_mem.sv =====
`default_nettype none
module acrb_result_mem #(
  parameter int CHANNELS = acrb_pkg::CHANNELS_DEF,
  parameter int GROUPS = acrb_pkg::GROUPS_DEF,
  parameter int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [GROUPS-1:0]                lane_en,
  input  logic [CW-1:0]                    waddr,
  input  logic [acrb_pkg::RES_W-1:0]        wdata,
  input  logic [CW-1:0]                    raddr,
  output logic [GROUPS*acrb_pkg::RES_W-1:0] rd_row
);
  import acrb_pkg::*;

  // one row per channel, one lane per group
  logic [GROUPS*RES_W-1:0] mem [CHANNELS];

  always_ff @(posedge clk) begin
    for (int g = 0; g < GROUPS; g++) begin
      if (we && lane_en[g]) begin
        mem[waddr][g*RES_W +: RES_W] <= wdata;
      end
    end
    rd_row <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/adc_conversion_register_block.sv =====
// Every item: transfer in, executed in the next cycle (S_EXEC), then S_FINISH registers the
// result onto the output; input ready again only once the block is back in S_IDLE.
// A tick that ends a conversion sweeps the level and result memories, one channel per
// cycle, through S_SWEEP, S_DRAIN and S_TAIL. A result that is not taken holds the block.
// Synchronous reset clears all control state and the valid bits of both memories at
// once; no clearing pass is run.
`default_nettype none
module adc_conversion_register_block #(
  parameter int CHANNELS       = acrb_pkg::CHANNELS_DEF,
  parameter int GROUPS         = acrb_pkg::GROUPS_DEF,
  parameter int LIMIT_REGS     = acrb_pkg::LIMIT_REGS_DEF,
  parameter int SELFTEST_TICKS = acrb_pkg::SELFTEST_TICKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [11:0] address,
  input  logic [31:0] write_data,
  input  logic [4:0]  channel,
  input  logic [15:0] level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        irq,
  output logic        done_pulse,
  output logic        busy_res
);
  import acrb_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RW = GROUPS * RES_W;

  state_t state, state_next;

  logic [2:0]  act;
  logic [11:0] addr_q;
  logic [31:0] wdata_q;
  logic [4:0]  chan_q;
  logic [15:0] level_q;
  logic        dhit, dhit_in;
  logic [1:0]  dg, dg_in;
  logic [CW-1:0] dch, dch_in;

  logic [31:0] ctrl, stat, delay, dmae, wstat, wmask;
  logic [31:0] stat_next;
  logic [1:0]  endf, endm;
  logic [31:0] done_f [GROUPS];
  logic [31:0] intm   [GROUPS];
  logic [31:0] nmask  [GROUPS];
  logic [31:0] jmask  [GROUPS];
  logic [31:0] timing [GROUPS];
  logic [31:0] dmar   [GROUPS];
  logic [31:0] lim    [LIMIT_REGS];
  logic [CHANNELS-1:0] rvalid  [GROUPS];
  logic [CHANNELS-1:0] latched [GROUPS];
  logic [9:0]  rem;
  logic        conv, cinj;
  logic [2:0]  st_step;
  logic [15:0] st_cnt;
  logic        st_run;
  logic        pulse;
  logic [31:0] rd_q;

  logic [CW-1:0] sw_idx, proc_ch;
  logic          proc_v;

  logic [CHANNELS-1:0] m_n [GROUPS];
  logic [CHANNELS-1:0] m_j [GROUPS];
  logic        any_n, any_j;
  logic [9:0]  cyc_n, cyc_j;
  logic        do_ns, do_js;
  logic        conv_go, go_inj, st_go;

  logic [15:0] st_cnt_inc;
  logic [2:0]  st_step_inc;
  logic        st_hit;

  logic [31:0] rd_val;
  logic        irq_val;

  logic [LEVEL_W-1:0] lvl_rd;
  logic               lvl_ok;
  logic               lvl_we;
  logic [RES_W-1:0]   val;
  logic               viol;
  logic [GROUPS-1:0]  lane_en;
  logic [31:0]        wd_bits;
  logic [5:0]         wbit [GROUPS];
  logic [RW-1:0]      res_row;

  acrb_level_mem #(.CHANNELS(CHANNELS), .CW(CW)) u_level (
    .clk     (clk),
    .rst     (rst),
    .we      (lvl_we),
    .waddr   (chan_q[CW-1:0]),
    .wdata   (level_q),
    .raddr   (sw_idx),
    .rd_data (lvl_rd),
    .rd_ok   (lvl_ok)
  );

  acrb_result_mem #(.CHANNELS(CHANNELS), .GROUPS(GROUPS), .CW(CW)) u_result (
    .clk     (clk),
    .we      (proc_v),
    .lane_en (lane_en),
    .waddr   (proc_ch),
    .wdata   (val),
    .raddr   (dch_in),
    .rd_row  (res_row)
  );

  always_comb begin
    logic [11:0] off;
    dhit_in = 1'b0;
    dg_in   = 2'd0;
    dch_in  = '0;
    off     = '0;
    for (int g = 0; g < GROUPS; g++) begin
      if (address[1:0] == 2'b00 && address >= DATA_BASE[g] &&
          int'(address) < int'(DATA_BASE[g]) +
          4 * ((DATA_CNT[g] < CHANNELS) ? DATA_CNT[g] : CHANNELS)) begin
        dhit_in = 1'b1;
        dg_in   = 2'(g);
        off     = address - DATA_BASE[g];
        dch_in  = off[CW+1:2];
      end
    end
  end

  always_comb begin
    any_n = 1'b0;
    any_j = 1'b0;
    cyc_n = '0;
    cyc_j = '0;
    for (int g = 0; g < GROUPS; g++) begin
      m_n[g] = nmask[g][CHANNELS-1:0];
      m_j[g] = (jmask[g] != 32'd0) ? jmask[g][CHANNELS-1:0] : nmask[g][CHANNELS-1:0];
      if (m_n[g] != '0) begin
        any_n = 1'b1;
        cyc_n = 10'(timing[g][7:0]) + 10'(timing[g][15:8]) + 10'(delay[7:0]);
      end
      if (m_j[g] != '0) begin
        any_j = 1'b1;
        cyc_j = 10'(timing[g][7:0]) + 10'(timing[g][15:8]) + 10'(delay[7:0]);
      end
    end
  end

  always_comb begin
    do_ns = 1'b0;
    do_js = 1'b0;
    if (state == S_EXEC && act == ACT_WRITE && addr_q == A_CTRL && !wdata_q[PWDN_BIT]) begin
      do_ns = wdata_q[NSTART_BIT];
      do_js = wdata_q[JSTART_BIT];
    end
    if (state == S_EXEC && act == ACT_TRIG && !ctrl[PWDN_BIT]) begin
      do_ns = 1'b1;
    end
    if (state == S_TAIL && ctrl[4:3] == SCAN_CONT && !cinj && !ctrl[PWDN_BIT]) begin
      do_ns = 1'b1;
    end
    // an injected start follows a normal one in the same write and wins
    go_inj  = do_js && any_j;
    conv_go = (do_ns && any_n) || go_inj;
    st_go   = (do_ns && !any_n) || (do_js && !any_j);
  end

  assign st_cnt_inc  = st_cnt + 16'd1;
  assign st_step_inc = st_step + 3'd1;
  assign st_hit      = st_cnt_inc >= 16'(SELFTEST_TICKS);

  always_comb begin
    stat_next = stat;
    if (state == S_EXEC && act == ACT_WRITE && addr_q == A_CTRL) begin
      if (!wdata_q[PWDN_BIT] && ctrl[PWDN_BIT]) stat_next[3:0] = NIB_IDLE;
      else if (wdata_q[PWDN_BIT] && wdata_q[MODEW_BIT]) stat_next[3:0] = NIB_ZERO;
    end
    if (state == S_EXEC && act == ACT_WRITE && addr_q == A_STAT) stat_next[3:0] = NIB_ZERO;
    if (state == S_EXEC && act == ACT_TICK && st_run && st_hit) begin
      stat_next[3:0] = {3'd0, ~st_step_inc[0]};
    end
    if (state == S_TAIL) stat_next = STAT_RST;
    if (do_js)      stat_next[3:0] = any_j ? NIB_CONV : NIB_IDLE;
    else if (do_ns) stat_next[3:0] = any_n ? NIB_CONV : NIB_IDLE;
  end

  always_comb begin
    rd_val = 32'd0;
    if (addr_q[1:0] == 2'b00) begin
      if (dhit) begin
        for (int g = 0; g < GROUPS; g++) begin
          if (dg == 2'(g) && rvalid[g][dch]) begin
            rd_val = {20'd0, res_row[g*RES_W +: RES_W]} | (32'd1 << VALID_BIT);
          end
        end
      end else begin
        case (addr_q)
          A_CTRL:  rd_val = ctrl;
          A_STAT:  rd_val = stat;
          A_END:   rd_val = {30'd0, endf};
          A_ENDM:  rd_val = {30'd0, endm};
          A_WSTAT: rd_val = wstat;
          A_WMASK: rd_val = wmask;
          A_DMAE:  rd_val = dmae;
          A_DELAY: rd_val = delay;
          A_CAL0:  rd_val = CAL0_VAL;
          A_CAL1:  rd_val = CAL1_VAL;
          A_CAL2:  rd_val = CAL2_VAL;
          default: begin
            for (int g = 0; g < GROUPS; g++) begin
              if (addr_q == 12'(A_DONE + 4 * g))  rd_val = done_f[g];
              if (addr_q == 12'(A_INTM + 4 * g))  rd_val = intm[g];
              if (addr_q == 12'(A_DMAR + 4 * g))  rd_val = dmar[g];
              if (addr_q == 12'(A_TIM + 4 * g))   rd_val = timing[g];
              if (addr_q == 12'(A_NMASK + 4 * g)) rd_val = nmask[g];
              if (addr_q == 12'(A_JMASK + 4 * g)) rd_val = jmask[g];
            end
            for (int w = 0; w < LIMIT_REGS; w++) begin
              if (addr_q == 12'(A_LIM + 4 * w)) rd_val = lim[w];
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    irq_val = ((endf & endm) != 2'd0) || ((wstat & wmask) != 32'd0);
    for (int g = 0; g < GROUPS; g++) begin
      if ((done_f[g] & intm[g]) != 32'd0) irq_val = 1'b1;
    end
  end

  // sweep: level of proc_ch arrives this cycle
  assign val = lvl_ok ? lvl_rd[15:4] : '0;

  always_comb begin
    viol    = 1'b0;
    wd_bits = '0;
    for (int w = 0; w < LIMIT_REGS; w++) begin
      if (16'(val) < lim[w][15:0] || 16'(val) > lim[w][31:16]) viol = 1'b1;
    end
    for (int g = 0; g < GROUPS; g++) begin
      lane_en[g] = latched[g][proc_ch];
      wbit[g]    = 6'(g * 8) + 6'(proc_ch);
      if (proc_v && lane_en[g] && wbit[g] < 6'd32 && wmask[wbit[g][4:0]] && viol) begin
        wd_bits[wbit[g][4:0]] = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_EXEC;
      S_EXEC:   state_next = (act == ACT_TICK && conv && rem <= 10'd1) ? S_SWEEP : S_FINISH;
      S_SWEEP:  if (sw_idx == CW'(CHANNELS - 1)) state_next = S_DRAIN;
      S_DRAIN:  state_next = S_TAIL;
      S_TAIL:   state_next = S_FINISH;
      S_FINISH: if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    lvl_we   = (state == S_EXEC) && (act == ACT_LEVEL) && (int'(chan_q) < CHANNELS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      proc_v    <= 1'b0;
      sw_idx    <= '0;
      ctrl      <= CTRL_RST;
      stat      <= STAT_RST;
      endf      <= '0;
      endm      <= '0;
      delay     <= '0;
      dmae      <= '0;
      wstat     <= '0;
      wmask     <= '0;
      for (int g = 0; g < GROUPS; g++) begin
        done_f[g]  <= '0;
        intm[g]    <= '0;
        nmask[g]   <= '0;
        jmask[g]   <= '0;
        timing[g]  <= TIMING_RST;
        dmar[g]    <= '0;
        rvalid[g]  <= '0;
        latched[g] <= '0;
      end
      for (int w = 0; w < LIMIT_REGS; w++) lim[w] <= '0;
      rem     <= '0;
      conv    <= 1'b0;
      cinj    <= 1'b0;
      st_step <= '0;
      st_cnt  <= '0;
      st_run  <= 1'b0;
      pulse   <= 1'b0;
    end else begin
      state   <= state_next;
      stat    <= stat_next;
      proc_v  <= (state == S_SWEEP);
      proc_ch <= sw_idx;
      if (state == S_SWEEP) sw_idx <= sw_idx + CW'(1);
      else                  sw_idx <= '0;

      if (in_valid && in_ready) begin
        act     <= action;
        addr_q  <= address;
        wdata_q <= write_data;
        chan_q  <= channel;
        level_q <= level;
        dhit    <= dhit_in;
        dg      <= dg_in;
        dch     <= dch_in;
      end

      if (state == S_EXEC) begin
        pulse <= (act == ACT_TICK) && conv && (rem <= 10'd1);
        rd_q  <= (act == ACT_READ) ? rd_val : 32'd0;
        case (act)
          ACT_WRITE: begin
            if (addr_q[1:0] == 2'b00) begin
              case (addr_q)
                A_CTRL:  ctrl <= wdata_q & ~((32'd1 << NSTART_BIT) | (32'd1 << JSTART_BIT));
                A_END:   endf <= endf & ~wdata_q[1:0];
                A_ENDM:  endm <= wdata_q[1:0];
                A_WSTAT: wstat <= wstat & ~wdata_q;
                A_WMASK: wmask <= wdata_q;
                A_DMAE:  dmae <= wdata_q;
                A_DELAY: delay <= wdata_q;
                default: begin
                  for (int g = 0; g < GROUPS; g++) begin
                    if (addr_q == 12'(A_DONE + 4 * g))  done_f[g] <= done_f[g] & ~wdata_q;
                    if (addr_q == 12'(A_INTM + 4 * g))  intm[g] <= wdata_q;
                    if (addr_q == 12'(A_DMAR + 4 * g))  dmar[g] <= wdata_q;
                    if (addr_q == 12'(A_TIM + 4 * g))   timing[g] <= wdata_q;
                    if (addr_q == 12'(A_NMASK + 4 * g)) nmask[g] <= wdata_q;
                    if (addr_q == 12'(A_JMASK + 4 * g)) jmask[g] <= wdata_q;
                  end
                  for (int w = 0; w < LIMIT_REGS; w++) begin
                    if (addr_q == 12'(A_LIM + 4 * w)) lim[w] <= wdata_q;
                  end
                end
              endcase
            end
          end
          ACT_TICK: begin
            if (st_run) begin
              st_cnt <= st_hit ? 16'd0 : st_cnt_inc;
              if (st_hit) begin
                st_step <= st_step_inc;
                if (st_step_inc >= 3'd3) st_run <= 1'b0;
              end
            end
            if (conv && rem > 10'd1) rem <= rem - 10'd1;
          end
          default: ;
        endcase
      end

      if (proc_v) begin
        for (int g = 0; g < GROUPS; g++) begin
          if (lane_en[g]) begin
            rvalid[g][proc_ch] <= 1'b1;
            done_f[g][proc_ch] <= 1'b1;
          end
        end
        wstat <= wstat | wd_bits;
      end

      if (state == S_TAIL) endf <= 2'b11;

      if (conv_go) begin
        for (int g = 0; g < GROUPS; g++) latched[g] <= go_inj ? m_j[g] : m_n[g];
        if (go_inj) rem <= (cyc_j == 10'd0) ? 10'd1 : cyc_j;
        else        rem <= (cyc_n == 10'd0) ? 10'd1 : cyc_n;
        conv <= 1'b1;
        cinj <= go_inj;
      end else if (state == S_TAIL) begin
        conv <= 1'b0;
        rem  <= '0;
      end

      if (st_go) begin
        st_step <= '0;
        st_cnt  <= '0;
        st_run  <= 1'b1;
      end

      if (state == S_FINISH && (!out_valid || out_ready)) begin
        out_valid  <= 1'b1;
        read_data  <= rd_q;
        irq        <= irq_val;
        done_pulse <= pulse;
        busy_res   <= conv;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/acrb_checker.sv =====
`default_nettype none
`include "adc_conversion_register_block_assert.svh"
module acrb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] read_data,
  input logic        done_pulse
);

  `ACRB_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
  `ACRB_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(!in_ready))
  `ACRB_ASSERT_NOW(a_done_reads_zero, out_valid && done_pulse, read_data == 32'd0)
  `ACRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data))

endmodule

bind adc_conversion_register_block acrb_checker u_acrb_checker (.*);
`default_nettype wire

// ===== tb/adc_conversion_register_block_tb.sv =====
`timescale 1ns / 1ps
module adc_conversion_register_block_tb;
  import acrb_pkg::*;

  localparam int CH = CHANNELS_DEF;
  localparam int NG = GROUPS_DEF;
  localparam int NL = LIMIT_REGS_DEF;
  localparam int RUN_ITEMS = 1700;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [2:0]  act;
    logic [11:0] addr;
    logic [31:0] data;
    logic [4:0]  chan;
    logic [15:0] lvl;
    bit          hold;
  } adc_item_t;

  typedef struct {
    logic [31:0] rd;
    logic        irq;
    logic        done;
    logic        busy;
  } adc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  action = '0;
  logic [11:0] address = '0;
  logic [31:0] write_data = '0;
  logic [4:0]  channel = '0;
  logic [15:0] level = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] read_data;
  logic        irq;
  logic        done_pulse;
  logic        busy_res;

  adc_conversion_register_block u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .address(address), .write_data(write_data),
    .channel(channel), .level(level),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_data(read_data), .irq(irq), .done_pulse(done_pulse), .busy_res(busy_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow register state
  logic [31:0] ctrl, stat, wstat, wmask, dly, dmae;
  logic [1:0]  endf, endm;
  logic [31:0] done_f[NG], intm[NG], nmask[NG], jmask[NG], tim[NG], dmar[NG];
  logic [31:0] rval[NG], lat[NG], lim[NL];
  logic [11:0] res[NG*CH];
  logic [15:0] lvl[CH];
  logic [9:0]  remc;
  logic [2:0]  st_step;
  logic [15:0] st_cnt;
  bit          conv, chinj, st_run;

  adc_item_t   pend[$];
  adc_result_t exp_q[$];
  int          items_total = 0;
  int          errors = 0;
  int          cycles = 0;

  function automatic void model_reset();
    ctrl = CTRL_RST; stat = STAT_RST; endf = '0; endm = '0;
    wstat = '0; wmask = '0; dly = '0; dmae = '0;
    for (int g = 0; g < NG; g++) begin
      done_f[g] = '0; intm[g] = '0; nmask[g] = '0; jmask[g] = '0;
      tim[g] = TIMING_RST; dmar[g] = '0; rval[g] = '0; lat[g] = '0;
    end
    for (int i = 0; i < NL; i++) lim[i] = '0;
    for (int i = 0; i < NG*CH; i++) res[i] = '0;
    for (int i = 0; i < CH; i++) lvl[i] = '0;
    remc = '0; conv = 0; chinj = 0; st_step = '0; st_cnt = '0; st_run = 0;
  endfunction

  function automatic void set_nib(logic [3:0] n);
    stat[3:0] = n;
  endfunction

  function automatic int grp(logic [31:0] a, logic [31:0] base);
    if (a >= base && a < base + 4*NG) return int'((a - base) >> 2);
    return -1;
  endfunction

  function automatic bit plain_reg(logic [31:0] a, bit wr, logic [31:0] v,
                                   output logic [31:0] q);
    int g;
    q = '0;
    if (a == A_WMASK) begin if (wr) wmask = v; q = wmask; return 1; end
    if (a == A_DMAE) begin if (wr) dmae = v; q = dmae; return 1; end
    if (a == A_DELAY) begin if (wr) dly = v; q = dly; return 1; end
    if (a >= A_LIM && a < A_LIM + 4*NL) begin
      g = int'((a - A_LIM) >> 2);
      if (wr) lim[g] = v;
      q = lim[g];
      return 1;
    end
    g = grp(a, A_INTM);
    if (g >= 0) begin if (wr) intm[g] = v; q = intm[g]; return 1; end
    g = grp(a, A_DMAR);
    if (g >= 0) begin if (wr) dmar[g] = v; q = dmar[g]; return 1; end
    g = grp(a, A_TIM);
    if (g >= 0) begin if (wr) tim[g] = v; q = tim[g]; return 1; end
    g = grp(a, A_NMASK);
    if (g >= 0) begin if (wr) nmask[g] = v; q = nmask[g]; return 1; end
    g = grp(a, A_JMASK);
    if (g >= 0) begin if (wr) jmask[g] = v; q = jmask[g]; return 1; end
    return 0;
  endfunction

  function automatic void start_chain(bit inj);
    logic [31:0] m[NG];
    logic [31:0] cyc;
    bit any;
    cyc = '0;
    any = 0;
    if (ctrl[PWDN_BIT]) return;
    for (int g = 0; g < NG; g++) begin
      m[g] = nmask[g];
      if (inj && jmask[g] != 0) m[g] = jmask[g];
      if (m[g] != 0) begin
        any = 1;
        cyc = 32'(tim[g][7:0]) + 32'(tim[g][15:8]) + 32'(dly[7:0]);
      end
    end
    if (!any) begin
      st_step = '0; st_cnt = '0; st_run = 1;
      set_nib(NIB_IDLE);
      return;
    end
    for (int g = 0; g < NG; g++) lat[g] = m[g];
    remc = (cyc != 0) ? cyc[9:0] : 10'd1;
    conv = 1;
    chinj = inj;
    set_nib(NIB_CONV);
  endfunction

  function automatic void complete_conv();
    logic [11:0] val;
    int wb;
    for (int g = 0; g < NG; g++)
      for (int c = 0; c < CH; c++)
        if (lat[g][c]) begin
          val = lvl[c][15:4];
          res[g*CH + c] = val;
          rval[g][c] = 1'b1;
          done_f[g][c] = 1'b1;
          wb = g*8 + c;
          if (wb < 32 && wmask[wb])
            for (int w = 0; w < NL; w++)
              if (16'(val) < lim[w][15:0] || 16'(val) > lim[w][31:16]) wstat[wb] = 1'b1;
        end
    conv = 0;
    remc = '0;
    stat = STAT_RST;
    endf = 2'b11;
    if (ctrl[4:3] == SCAN_CONT && !chinj) start_chain(0);
  endfunction

  function automatic logic [31:0] bus_read(logic [31:0] a);
    logic [31:0] q;
    int g;
    int c;
    if (a[1:0] != 0) return '0;
    for (g = 0; g < NG; g++)
      if (a >= 32'(DATA_BASE[g]) && a < 32'(DATA_BASE[g]) + 4*DATA_CNT[g]) begin
        c = int'((a - 32'(DATA_BASE[g])) >> 2);
        return {12'b0, rval[g][c], 7'b0, res[g*CH + c]};
      end
    case (a)
      A_CTRL:  return ctrl;
      A_STAT:  return stat;
      A_END:   return {30'b0, endf};
      A_ENDM:  return {30'b0, endm};
      A_WSTAT: return wstat;
      A_CAL0:  return CAL0_VAL;
      A_CAL1:  return CAL1_VAL;
      A_CAL2:  return CAL2_VAL;
      default: ;
    endcase
    g = grp(a, A_DONE);
    if (g >= 0) return done_f[g];
    void'(plain_reg(a, 0, '0, q));
    return q;
  endfunction

  function automatic void bus_write(logic [31:0] a, logic [31:0] v);
    logic [31:0] q;
    bit was_down;
    int g;
    if (a[1:0] != 0) return;
    if (a == A_CTRL) begin
      was_down = ctrl[PWDN_BIT];
      ctrl = v;
      ctrl[NSTART_BIT] = 1'b0;
      ctrl[JSTART_BIT] = 1'b0;
      if (!v[PWDN_BIT] && was_down) set_nib(NIB_IDLE);
      else if (v[PWDN_BIT] && v[MODEW_BIT]) set_nib(NIB_ZERO);
      if (v[NSTART_BIT]) start_chain(0);
      if (v[JSTART_BIT]) start_chain(1);
      return;
    end
    if (a == A_STAT) begin set_nib(NIB_ZERO); return; end
    if (a == A_END) begin endf = endf & ~v[1:0]; return; end
    if (a == A_ENDM) begin endm = v[1:0]; return; end
    if (a == A_WSTAT) begin wstat = wstat & ~v; return; end
    g = grp(a, A_DONE);
    if (g >= 0) begin done_f[g] = done_f[g] & ~v; return; end
    void'(plain_reg(a, 1, v, q));
  endfunction

  function automatic adc_result_t predict_item(adc_item_t it);
    adc_result_t r;
    r.rd = '0; r.irq = 0; r.done = 0; r.busy = 0;
    case (it.act)
      ACT_READ:  r.rd = bus_read(32'(it.addr));
      ACT_WRITE: bus_write(32'(it.addr), it.data);
      ACT_TICK: begin
        if (st_run) begin
          st_cnt = st_cnt + 16'd1;
          if (st_cnt >= SELFTEST_TICKS_DEF) begin
            st_cnt = '0;
            st_step = st_step + 3'd1;
            set_nib({3'b0, ~st_step[0]});
            if (st_step >= 3) st_run = 0;
          end
        end
        if (conv) begin
          if (remc > 1) remc = remc - 10'd1;
          else begin
            r.done = 1;
            complete_conv();
          end
        end
      end
      ACT_LEVEL: lvl[it.chan] = it.lvl;
      ACT_TRIG:  start_chain(0);
      default: ;
    endcase
    r.irq = ((endf & endm) != 0) || ((wstat & wmask) != 0);
    for (int g = 0; g < NG; g++)
      if ((done_f[g] & intm[g]) != 0) r.irq = 1;
    r.busy = conv;
    return r;
  endfunction

  task automatic push(logic [2:0] a, logic [11:0] ad, logic [31:0] d,
                      logic [4:0] c, logic [15:0] l);
    adc_item_t it;
    it.act = a; it.addr = ad; it.data = d; it.chan = c; it.lvl = l; it.hold = 0;
    pend.push_back(it);
    items_total++;
  endtask

  task automatic rd(logic [11:0] a);
    push(ACT_READ, a, $urandom, 5'($urandom), 16'($urandom));
  endtask

  task automatic wr(logic [11:0] a, logic [31:0] d);
    push(ACT_WRITE, a, d, 5'($urandom), 16'($urandom));
  endtask

  task automatic tick();
    push(ACT_TICK, 12'($urandom), $urandom, 5'($urandom), 16'($urandom));
  endtask

  task automatic set_level(logic [4:0] c, logic [15:0] l);
    push(ACT_LEVEL, 12'($urandom), $urandom, c, l);
  endtask

  task automatic hold_until_drained();
    adc_item_t it;
    it.act = ACT_READ; it.addr = '0; it.data = '0; it.chan = '0; it.lvl = '0;
    it.hold = 1;
    pend.push_back(it);
  endtask

  function automatic logic [11:0] pick_addr();
    logic [11:0] bases[17];
    bases = '{A_CTRL, A_STAT, A_END, A_DONE, A_ENDM, A_INTM, A_WSTAT, A_WMASK,
              A_DMAE, A_DMAR, A_LIM, A_TIM, A_NMASK, A_JMASK, A_DELAY, A_CAL0,
              DATA_BASE[$urandom_range(0, 2)]};
    if ($urandom_range(0, 3) == 0) return 12'($urandom);
    return bases[$urandom_range(0, 16)] + 12'(4 * $urandom_range(0, 3));
  endfunction

  function automatic logic [11:0] data_addr();
    int g;
    g = $urandom_range(0, 2);
    return DATA_BASE[g] + 12'(4 * $urandom_range(0, DATA_CNT[g] - 1));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic conversion_run();
    logic [1:0] scan;
    logic [31:0] cbase;
    int n;
    bit long_t;
    bit allow_long;
    scan = 2'($urandom_range(0, 3));
    cbase = 32'(scan) << 3;
    if ($urandom_range(0, 7) == 0) cbase[MODEW_BIT] = 1'b1;
    long_t = 0;
    allow_long = (items_total + 1000 < RUN_ITEMS);
    wr(A_CTRL, cbase);
    repeat ($urandom_range(1, 5)) set_level(5'($urandom), 16'($urandom));
    for (int g = 0; g < NG; g++) begin
      if ($urandom_range(0, 1) == 0)
        wr(A_NMASK + 12'(4*g), ($urandom_range(0, 5) == 0) ? $urandom : ($urandom & $urandom));
      if ($urandom_range(0, 2) == 0)
        wr(A_JMASK + 12'(4*g), ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom);
      if (allow_long && $urandom_range(0, 15) == 0) begin
        wr(A_TIM + 12'(4*g), $urandom);
        long_t = 1;
      end else
        wr(A_TIM + 12'(4*g), {16'($urandom_range(0, 65535)), 8'($urandom_range(0, 3)),
                              8'($urandom_range(0, 6))});
      if ($urandom_range(0, 3) == 0) wr(A_INTM + 12'(4*g), $urandom);
    end
    if (allow_long && $urandom_range(0, 15) == 0) begin
      wr(A_DELAY, $urandom);
      long_t = 1;
    end else
      wr(A_DELAY, {24'($urandom_range(0, 16777215)), 8'($urandom_range(0, 3))});
    if ($urandom_range(0, 2) == 0) wr(A_WMASK, $urandom);
    if ($urandom_range(0, 2) == 0)
      wr(A_LIM + 12'(4*$urandom_range(0, NL-1)),
         {16'($urandom_range(2048, 4095)), 16'($urandom_range(0, 2047))});
    if ($urandom_range(0, 3) == 0) wr(A_ENDM, $urandom);
    case ($urandom_range(0, 3))
      0: wr(A_CTRL, cbase | (32'h1 << NSTART_BIT));
      1: wr(A_CTRL, cbase | (32'h1 << JSTART_BIT));
      2: wr(A_CTRL, cbase | (32'h1 << NSTART_BIT) | (32'h1 << JSTART_BIT));
      default: push(ACT_TRIG, 12'($urandom), $urandom, 5'($urandom), 16'($urandom));
    endcase
    n = long_t ? 800 : $urandom_range(1, 40);
    repeat (n) begin
      tick();
      case ($urandom_range(0, 11))
        0: rd(data_addr());
        1: rd(A_STAT);
        2: set_level(5'($urandom), 16'($urandom));
        3: if ($urandom_range(0, 3) == 0)
             push(ACT_TRIG, 12'($urandom), $urandom, 5'($urandom), 16'($urandom));
        default: ;
      endcase
    end
    repeat ($urandom_range(1, 4)) rd(data_addr());
    rd(A_DONE + 12'(4*$urandom_range(0, 2)));
    rd(A_WSTAT);
    rd(A_END);
    if ($urandom_range(0, 1) == 0) wr(A_DONE + 12'(4*$urandom_range(0, 2)), $urandom);
    if ($urandom_range(0, 1) == 0) wr(A_WSTAT, $urandom);
    if ($urandom_range(0, 1) == 0) wr(A_END, $urandom);
    if (scan == SCAN_CONT && $urandom_range(0, 1) == 0) wr(A_CTRL, 32'h0);
  endtask

  task automatic selftest_run();
    wr(A_CTRL, 32'h0);
    for (int g = 0; g < NG; g++) wr(A_NMASK + 12'(4*g), 32'h0);
    if ($urandom_range(0, 1) == 0) wr(A_CTRL, 32'h1 << NSTART_BIT);
    else push(ACT_TRIG, 12'($urandom), $urandom, 5'($urandom), 16'($urandom));
    repeat (3 * SELFTEST_TICKS_DEF + 5) begin
      tick();
      if ($urandom_range(0, 15) == 0) rd(A_STAT);
    end
    rd(A_STAT);
  endtask

  // driver
  bit in_took = 0;
  int in_gap = 0;
  int hold_cnt = 0;
  int out_stall = 0;

  always @(negedge clk) begin : drive
    adc_item_t it;
    if (!rst) begin
      if (!in_valid || in_took) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pend.size() > 0 && pend[0].hold) begin
          in_valid <= 1'b0;
          if (exp_q.size() == 0) begin
            if (hold_cnt >= DRAIN_CYCLES) begin
              void'(pend.pop_front());
              hold_cnt <= 0;
            end else
              hold_cnt <= hold_cnt + 1;
          end
        end else if (pend.size() > 0) begin
          it = pend.pop_front();
          action <= it.act;
          address <= it.addr;
          write_data <= it.data;
          channel <= it.chan;
          level <= it.lvl;
          in_valid <= 1'b1;
          in_gap <= pick_gap();
        end else
          in_valid <= 1'b0;
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) out_stall <= pick_gap() + 1;
      end
    end
  end

  // monitor and predictor
  always @(posedge clk) begin : monitor
    adc_result_t e;
    adc_item_t it;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    in_took = 0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (exp_q.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          e = exp_q.pop_front();
          if (read_data !== e.rd) begin
            $error("read_data expected %h actual %h", e.rd, read_data); errors++;
          end
          if (irq !== e.irq) begin
            $error("irq expected %0d actual %0d", e.irq, irq); errors++;
          end
          if (done_pulse !== e.done) begin
            $error("done_pulse expected %0d actual %0d", e.done, done_pulse); errors++;
          end
          if (busy_res !== e.busy) begin
            $error("busy_res expected %0d actual %0d", e.busy, busy_res); errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        in_took = 1;
        it.act = action; it.addr = address; it.data = write_data;
        it.chan = channel; it.lvl = level; it.hold = 0;
        exp_q.push_back(predict_item(it));
      end
    end
  end

  initial begin
    model_reset();
    // directed
    rd(A_CTRL); rd(A_STAT); rd(A_CAL0); rd(A_CAL1); rd(A_CAL2);
    rd(12'h003); rd(12'hFFC);
    wr(A_CTRL, 32'h1 | (32'h1 << NSTART_BIT));
    wr(A_CTRL, 32'h0);
    wr(A_CTRL, 32'h3);
    wr(A_CTRL, 32'h0);
    set_level(5'd0, 16'hFFFF);
    set_level(5'd31, 16'h0000);
    wr(A_NMASK, 32'h1);
    wr(A_NMASK + 12'd8, 32'h8000_0000);
    wr(A_TIM + 12'd8, 32'h0);
    wr(A_WMASK, 32'hFFFF_FFFF);
    wr(A_LIM, 32'h0800_0010);
    wr(A_ENDM, 32'h3);
    wr(A_CTRL, 32'h1 << NSTART_BIT);
    tick(); tick();
    rd(A_WSTAT);
    push(3'd5, 12'hFFF, 32'hFFFF_FFFF, 5'd31, 16'hFFFF);
    push(3'd7, 12'h000, 32'h0, 5'd0, 16'h0);
    wr(A_STAT, 32'h0);
    hold_until_drained();
    while (items_total < RUN_ITEMS) begin
      case ($urandom_range(0, 11))
        0, 1: repeat ($urandom_range(1, 6))
                push(3'($urandom), pick_addr(), $urandom, 5'($urandom), 16'($urandom));
        2: selftest_run();
        3: hold_until_drained();
        default: conversion_run();
      endcase
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (pend.size() > 0 || in_valid) @(posedge clk);
    while (exp_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
